// File: rtl/core/ops_pkg.sv
// shared widths and constants for the odd-only prime sieve
package ops_pkg;

	localparam int unsigned DEF_MAX_LIMIT = 1048576;
	localparam int unsigned LIMIT_W       = 21;
	localparam int unsigned LIMIT_RESET   = 750000;
	localparam int unsigned PRIME_W       = 20;
	localparam int unsigned NUM_W         = 22;
	localparam int unsigned MARK_W        = 23;
	localparam int unsigned PROD_W        = 2 * NUM_W;
	localparam int unsigned IN_TDATA_W    = 8;
	localparam int unsigned OUT_TDATA_W   = 24;

endpackage

// File: rtl/core/ops_ram.sv
// generic simple dual-port ram with registered read
module ops_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16384,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/core/odd_only_prime_sieve.sv
// odd-only prime sieve top level: request/answer streams, sequencer and mark store
//
// Each request on the input stream returns the next prime below
// min(sieve_limit, MAX_LIMIT) on the output stream, starting from 2, or
// exhausted with value 0 once no candidate is left. Composite flags for odd
// numbers live in one ram of 32-flag rows (8-flag rows when MAX_LIMIT < 64)
// with one write and one registered read port; a small sequencer walks it.
// A request passes through setup, then scans upward over the candidates,
// reading each ram row it enters and skipping composite ones, then marks
// the multiples of the prime it found from its square up, row by row,
// writing each row back as it leaves it. One request is in work at a
// time and a new one is taken once the previous answer is transferred.
// After reset the block clears the whole store, one row per cycle,
// before taking a request; a request with restart set first clears rows
// up to the highest row marked so far, then answers 2, or exhausted if
// the limit is 2 or less. Configuration writes are taken at any time.
module odd_only_prime_sieve #(
	parameter int unsigned MAX_LIMIT = ops_pkg::DEF_MAX_LIMIT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [ops_pkg::LIMIT_W-1:0]      cfg_wr_data,   // sieve_limit
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [ops_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [0] restart
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [ops_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [19:0] prime_value
	output logic [0:0]                       m_axis_tuser   // [0] exhausted
);

	localparam int unsigned RW   = (MAX_LIMIT >= 64) ? 32 : 8;
	localparam int unsigned RB   = $clog2(RW);
	localparam int unsigned BITS = MAX_LIMIT / 2;
	localparam int unsigned ROWS = (BITS + RW - 1) / RW;
	localparam int unsigned AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned CAP  = (MAX_LIMIT < 2 ** ops_pkg::LIMIT_W) ?
		MAX_LIMIT : 2 ** ops_pkg::LIMIT_W - 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_MUL_CHK,
		ST_MARK
	} state_t;

	function automatic logic [AW-1:0] row_of(input logic [ops_pkg::MARK_W-1:0] n);
		return AW'(n >> (RB + 1));
	endfunction

	state_t                          state_q;
	logic [ops_pkg::LIMIT_W-1:0]     limit_q;
	logic [ops_pkg::NUM_W-1:0]       cand_q;
	logic [ops_pkg::PROD_W-1:0]      prod_q;
	logic [ops_pkg::MARK_W-1:0]      m_q;
	logic [ops_pkg::MARK_W-1:0]      step_q;
	logic [RW-1:0]                   buf_q;
	logic                            fresh_q;
	logic [AW-1:0]                   cur_row_q;
	logic [AW-1:0]                   hi_q;
	logic [AW-1:0]                   clr_q;
	logic                            pend_q;
	logic                            out_valid_q;
	logic [ops_pkg::PRIME_W-1:0]     prime_q;
	logic                            exh_q;

	logic [ops_pkg::NUM_W-1:0]       lim;
	logic                            cand_lt;
	logic                            prod_lt;
	logic                            m_lt;
	logic                            m_in_row;
	logic [RW-1:0]                   row_cur;

	logic                            ram_wr_en;
	logic [AW-1:0]                   ram_wr_addr;
	logic [RW-1:0]                   ram_wr_data;
	logic                            ram_rd_en;
	logic [AW-1:0]                   ram_rd_addr;
	logic [RW-1:0]                   ram_rd_data;

	assign lim = (ops_pkg::NUM_W'(limit_q) > ops_pkg::NUM_W'(CAP)) ?
		ops_pkg::NUM_W'(CAP) : ops_pkg::NUM_W'(limit_q);
	assign cand_lt  = cand_q < lim;
	assign prod_lt  = prod_q < ops_pkg::PROD_W'(lim);
	assign m_lt     = m_q < ops_pkg::MARK_W'(lim);
	assign m_in_row = m_lt && (row_of(m_q) == cur_row_q);
	assign row_cur  = fresh_q ? ram_rd_data : buf_q;

	assign s_axis_tready = (state_q == ST_IDLE) && !out_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = ops_pkg::OUT_TDATA_W'(prime_q);
	assign m_axis_tuser  = exh_q;

	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = clr_q;
		ram_wr_data = '0;
		ram_rd_en   = 1'b0;
		ram_rd_addr = row_of(ops_pkg::MARK_W'(cand_q));
		case (state_q)
			ST_CLEAR: begin
				ram_wr_en = 1'b1;
			end
			ST_SCAN_RD: begin
				ram_rd_en = cand_lt;
			end
			ST_MUL_CHK: begin
				ram_rd_en   = prod_lt;
				ram_rd_addr = row_of(prod_q[ops_pkg::MARK_W-1:0]);
			end
			ST_MARK: begin
				if (!m_in_row) begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = cur_row_q;
					ram_wr_data = row_cur;
					ram_rd_en   = m_lt;
					ram_rd_addr = row_of(m_q);
				end
			end
			default: begin
			end
		endcase
	end

	ops_ram #(
		.WIDTH(RW),
		.DEPTH(ROWS)
	) u_marks (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			limit_q     <= ops_pkg::LIMIT_W'(ops_pkg::LIMIT_RESET);
			cand_q      <= ops_pkg::NUM_W'(2);
			clr_q       <= '0;
			hi_q        <= AW'(ROWS - 1);
			pend_q      <= 1'b0;
			fresh_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == hi_q) begin
						hi_q    <= '0;
						cand_q  <= ops_pkg::NUM_W'(2);
						pend_q  <= 1'b0;
						state_q <= pend_q ? ST_START : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						if (s_axis_tdata[0]) begin
							clr_q   <= '0;
							pend_q  <= 1'b1;
							state_q <= ST_CLEAR;
						end else begin
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					if (cand_q == ops_pkg::NUM_W'(2)) begin
						if (lim > ops_pkg::NUM_W'(2)) begin
							cand_q  <= ops_pkg::NUM_W'(3);
							prime_q <= ops_pkg::PRIME_W'(2);
							exh_q   <= 1'b0;
						end else begin
							prime_q <= '0;
							exh_q   <= 1'b1;
						end
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SCAN_RD: begin
					if (cand_lt) begin
						state_q <= ST_SCAN_CHK;
					end else begin
						prime_q     <= '0;
						exh_q       <= 1'b1;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_SCAN_CHK: begin
					if (!cand_lt) begin
						prime_q     <= '0;
						exh_q       <= 1'b1;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else if (ram_rd_data[cand_q[RB:1]]) begin
						cand_q <= cand_q + ops_pkg::NUM_W'(2);
						if (&cand_q[RB:1]) begin
							state_q <= ST_SCAN_RD;
						end
					end else begin
						prod_q  <= cand_q * cand_q;
						state_q <= ST_MUL_CHK;
					end
				end
				ST_MUL_CHK: begin
					prime_q <= cand_q[ops_pkg::PRIME_W-1:0];
					exh_q   <= 1'b0;
					cand_q  <= cand_q + ops_pkg::NUM_W'(2);
					if (prod_lt) begin
						m_q       <= prod_q[ops_pkg::MARK_W-1:0];
						step_q    <= {cand_q, 1'b0};
						cur_row_q <= row_of(prod_q[ops_pkg::MARK_W-1:0]);
						fresh_q   <= 1'b1;
						state_q   <= ST_MARK;
					end else begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_MARK: begin
					if (m_in_row) begin
						buf_q   <= row_cur | (RW'(1) << m_q[RB:1]);
						m_q     <= m_q + step_q;
						fresh_q <= 1'b0;
					end else begin
						if (cur_row_q > hi_q) begin
							hi_q <= cur_row_q;
						end
						if (m_lt) begin
							cur_row_q <= row_of(m_q);
							fresh_q   <= 1'b1;
						end else begin
							out_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_wr_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr_en |-> (state_q == ST_CLEAR || state_q == ST_MARK))
		else $error("mark store written outside clear or mark phase");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("second request taken while one is in work");

	a_exh_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
		else $error("exhausted answer carries a nonzero value");

	a_prime_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |->
			(m_axis_tdata[0] || m_axis_tdata == ops_pkg::OUT_TDATA_W'(2)))
		else $error("even value other than two returned as prime");

	a_mark_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MARK && m_in_row) |-> (m_q >= ops_pkg::MARK_W'(9)))
		else $error("marking below the square of the smallest odd prime");

endmodule

// File: verif/odd_only_prime_sieve_test.sv
// self-checking testbench for the odd-only prime sieve: directed and random request streams
module odd_only_prime_sieve_test;

	localparam int unsigned MAX_LIM     = ops_pkg::DEF_MAX_LIMIT;
	localparam int unsigned FLAG_DEPTH  = MAX_LIM / 2;
	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned ITEM_TARGET = 1150;

	typedef struct packed {
		logic [ops_pkg::PRIME_W-1:0] prime;
		logic                        exhausted;
	} answer_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_wr_en;
	logic [ops_pkg::LIMIT_W-1:0]     cfg_wr_data;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [ops_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // [0] restart
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [ops_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // [19:0] prime_value
	logic [0:0]                      m_axis_tuser;   // [0] exhausted

	// sieve state mirrored on the testbench side
	bit          composite_flag [FLAG_DEPTH];
	int          flag_top;
	int unsigned model_candidate;
	int unsigned model_limit;

	answer_t     answers_due [$];
	int unsigned cycle_count;
	int          mismatches;
	int          src_idle;
	int          sink_stall;
	int          hold_cycles;
	int          requests_sent;
	int          restarts_sent;
	int          limits_written;
	int          primes_seen;
	int          exhausted_seen;

	odd_only_prime_sieve i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d answers outstanding", cycle_count,
			answers_due.size());
		$display("Test completed with failures");
		$finish;
	end

	function automatic answer_t next_prime_answer(bit restart);
		int unsigned lim;
		int unsigned c;
		longint unsigned m;
		longint unsigned stride;
		answer_t a;
		lim = (model_limit > MAX_LIM) ? MAX_LIM : model_limit;
		if (restart) begin
			for (int i = 0; i <= flag_top; i++) composite_flag[i] = 1'b0;
			flag_top = -1;
			model_candidate = 2;
		end
		a.prime = '0;
		a.exhausted = 1'b1;
		if (model_candidate == 2) begin
			if (lim > 2) begin
				model_candidate = 3;
				a.prime = ops_pkg::PRIME_W'(2);
				a.exhausted = 1'b0;
			end
			return a;
		end
		c = model_candidate;
		while (c < lim && composite_flag[c >> 1]) c += 2;
		if (c >= lim) begin
			model_candidate = c;
			return a;
		end
		m = 64'(c);
		m = m * 64'(c);
		stride = 2 * 64'(c);
		while (m < 64'(lim)) begin
			composite_flag[m >> 1] = 1'b1;
			if (int'(m >> 1) > flag_top) flag_top = int'(m >> 1);
			m += stride;
		end
		model_candidate = c + 2;
		a.prime = c[ops_pkg::PRIME_W-1:0];
		a.exhausted = 1'b0;
		return a;
	endfunction

	// answer side: checks every transfer, then decides the next tready
	initial begin
		answer_t due;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				if (answers_due.size() == 0) begin
					$error("answer with none outstanding: prime_value %0d exhausted %0d",
						m_axis_tdata[ops_pkg::PRIME_W-1:0], m_axis_tuser[0]);
					mismatches++;
				end else begin
					due = answers_due.pop_front();
					if (m_axis_tdata[ops_pkg::PRIME_W-1:0] !== due.prime) begin
						$error("prime_value: expected %0d, got %0d", due.prime,
							m_axis_tdata[ops_pkg::PRIME_W-1:0]);
						mismatches++;
					end
					if (m_axis_tuser[0] !== due.exhausted) begin
						$error("exhausted: expected %0d, got %0d", due.exhausted,
							m_axis_tuser[0]);
						mismatches++;
					end
					if (due.exhausted) exhausted_seen++;
					else primes_seen++;
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_stall);
			end
		end
	end

	task automatic send_request(input bit restart);
		cfg_wr_en <= 1'b0;
		if ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(ops_pkg::IN_TDATA_W-1){1'b0}}, restart};
		do @(posedge clk); while (!s_axis_tready);
		answers_due.push_back(next_prime_answer(restart));
		requests_sent++;
		if (restart) restarts_sent++;
	endtask

	task automatic finish_outstanding();
		s_axis_tvalid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
	endtask

	// only called with nothing in flight
	task automatic set_sieve_limit(input int unsigned value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value[ops_pkg::LIMIT_W-1:0];
		@(posedge clk);
		model_limit = value & ((1 << ops_pkg::LIMIT_W) - 1);
		limits_written++;
	endtask

	task automatic test_reset_limit();
		send_request(1'b0);
		send_request(1'b1);
		finish_outstanding();
	endtask

	task automatic test_small_limits();
		set_sieve_limit(2);
		send_request(1'b1);
		send_request(1'b0);
		finish_outstanding();
		set_sieve_limit(0);
		send_request(1'b0);
		finish_outstanding();
		set_sieve_limit(1);
		send_request(1'b1);
		finish_outstanding();
		set_sieve_limit(3);
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b0);
		finish_outstanding();
		// raise without restart: enumeration resumes, missing marks can leak composites
		set_sieve_limit(12);
		repeat (5) send_request(1'b0);
		finish_outstanding();
		set_sieve_limit(40);
		repeat (2) send_request(1'b0);
		finish_outstanding();
	endtask

	task automatic test_saturated_limit();
		set_sieve_limit((1 << ops_pkg::LIMIT_W) - 1);
		send_request(1'b1);
		send_request(1'b0);
		finish_outstanding();
	endtask

	task automatic test_backpressure();
		set_sieve_limit(500);
		hold_cycles = 400;
		send_request(1'b1);
		repeat (5) send_request(1'b0);
		finish_outstanding();
	endtask

	task automatic test_random_runs(input int src, input int sink, input int items);
		int unsigned lim;
		int sel;
		int run_len;
		int done;
		src_idle = src;
		sink_stall = sink;
		done = 0;
		while (done < items) begin
			finish_outstanding();
			sel = $urandom_range(99);
			if (sel < 5) lim = $urandom_range(0, 2);
			else if (sel < 45) lim = $urandom_range(3, 300);
			else if (sel < 90) lim = $urandom_range(300, 5000);
			else lim = $urandom_range(5000, 60000);
			set_sieve_limit(lim);
			run_len = $urandom_range(4, 48);
			for (int k = 0; k < run_len; k++) begin
				if (k == 0) send_request($urandom_range(99) < 80);
				else send_request($urandom_range(99) < 3);
			end
			done += run_len;
		end
		finish_outstanding();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cycle_count = 0;
		mismatches = 0;
		src_idle = 0;
		sink_stall = 0;
		hold_cycles = 0;
		requests_sent = 0;
		restarts_sent = 0;
		limits_written = 0;
		primes_seen = 0;
		exhausted_seen = 0;
		flag_top = -1;
		model_candidate = 2;
		model_limit = ops_pkg::LIMIT_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_limit();
		test_small_limits();
		test_saturated_limit();
		test_backpressure();
		test_random_runs(0, 0, (ITEM_TARGET - requests_sent) / 4);
		test_random_runs(80, 0, (ITEM_TARGET - requests_sent) / 3);
		test_random_runs(0, 80, (ITEM_TARGET - requests_sent) / 2);
		test_random_runs(32, 32, ITEM_TARGET - requests_sent);

		repeat (100) @(posedge clk);
		if (answers_due.size() != 0) begin
			$error("%0d answers never arrived", answers_due.size());
			mismatches++;
		end
		$display("covered %0d requests (%0d with restart) across %0d limit writes",
			requests_sent, restarts_sent, limits_written);
		$display("checked %0d primes and %0d exhausted answers in %0d cycles",
			primes_seen, exhausted_seen, cycle_count);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
